[rtl/lzw_pkg.sv]
// ----------------------------------------------------------------------------
// lzw_pkg
// Shared types, constants and helper functions for the LZW compressor.
// ----------------------------------------------------------------------------
package lzw_pkg;

  localparam int CODE_W      = 12;
  localparam int NFC_W       = 13;
  localparam int KEY_W       = 20;
  localparam int HASH_AW     = 13;
  localparam int ENTRY_DEPTH = 3840;
  localparam int ENTRY_AW    = 12;
  localparam logic [NFC_W-1:0] FIRST_CODE = 13'd256;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       eos;
  } item_t;

  function automatic logic [HASH_AW-1:0] hash_key(input logic [KEY_W-1:0] key);
    hash_key = key[HASH_AW-1:0] ^ {6'b0, key[KEY_W-1:HASH_AW]};
  endfunction

  function automatic logic [3:0] width_for(input logic [NFC_W-1:0] nfc);
    if (nfc <= 13'd256) begin
      width_for = 4'd8;
    end else if (nfc <= 13'd512) begin
      width_for = 4'd9;
    end else if (nfc <= 13'd1024) begin
      width_for = 4'd10;
    end else if (nfc <= 13'd2048) begin
      width_for = 4'd11;
    end else begin
      width_for = 4'd12;
    end
  endfunction

endpackage

[rtl/lzw_front.sv]
// ----------------------------------------------------------------------------
// lzw_front
// Accepts input bytes and holds them in a two-entry queue for the core.
// ----------------------------------------------------------------------------
module lzw_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_end_of_stream,
  output logic                item_valid,
  output lzw_pkg::item_t      item,
  input  logic                item_pop
);

  lzw_pkg::item_t slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       push;

  assign in_ready   = (count_r != 2'd2);
  assign push       = in_valid && in_ready;
  assign item_valid = (count_r != 2'd0);
  assign item       = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= '{data_byte: in_data_byte, eos: in_end_of_stream};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (item_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, item_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[rtl/lzw_core.sv]
// ----------------------------------------------------------------------------
// lzw_core
// Dictionary lookup, insert and code emission for one byte at a time.
// ----------------------------------------------------------------------------
module lzw_core #(
  parameter int DICT_SIZE = 4096
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_valid,
  input  lzw_pkg::item_t  item,
  output logic            item_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [11:0]     out_code,
  output logic [3:0]      out_code_bits,
  output logic            out_last_code
);

  localparam int DICT_LIMIT = (DICT_SIZE < 4096) ? DICT_SIZE : 4096;

  typedef enum logic [2:0] {S_IDLE, S_PA, S_PB, S_EMIT, S_EOS} state_t;

  state_t state_r, state_nxt;

  logic [lzw_pkg::CODE_W-1:0]  hash_mem [1 << lzw_pkg::HASH_AW];
  logic [lzw_pkg::KEY_W+lzw_pkg::HASH_AW-1:0] entry_mem [lzw_pkg::ENTRY_DEPTH];

  logic [lzw_pkg::CODE_W-1:0]  hash_q_r;
  logic [lzw_pkg::KEY_W+lzw_pkg::HASH_AW-1:0] entry_q_r;

  logic [lzw_pkg::CODE_W-1:0]  prefix_r, prefix_nxt;
  logic                        pv_r, pv_nxt;
  logic [lzw_pkg::NFC_W-1:0]   nfc_r, nfc_nxt;
  logic [lzw_pkg::HASH_AW-1:0] h_r, h_nxt;
  logic [lzw_pkg::KEY_W-1:0]   key_r, key_nxt;
  logic [7:0]                  byte_r, byte_nxt;
  logic                        eos_r, eos_nxt;
  logic [lzw_pkg::CODE_W-1:0]  res_code_r, res_code_nxt;
  logic [3:0]                  res_bits_r, res_bits_nxt;

  logic                        ov_r, ov_nxt;
  logic [11:0]                 oc_r, oc_nxt;
  logic [3:0]                  ob_r, ob_nxt;
  logic                        ol_r, ol_nxt;

  logic                        out_free, cand, live, do_miss, do_ins;
  logic [lzw_pkg::ENTRY_AW-1:0] ent_rd, ent_wr;
  logic [lzw_pkg::KEY_W-1:0]   new_key;

  assign out_valid     = ov_r;
  assign out_code      = oc_r;
  assign out_code_bits = ob_r;
  assign out_last_code = ol_r;
  assign out_free      = !ov_r || out_ready;

  assign new_key = {prefix_r, item.data_byte};
  assign cand    = ({1'b0, hash_q_r} >= lzw_pkg::FIRST_CODE) && ({1'b0, hash_q_r} < nfc_r);
  assign live    = cand && (entry_q_r[lzw_pkg::HASH_AW-1:0] == h_r);
  assign ent_rd  = hash_q_r - 12'd256;
  assign ent_wr  = nfc_r[lzw_pkg::ENTRY_AW-1:0] - 12'd256;
  assign do_ins  = do_miss && (nfc_r < lzw_pkg::NFC_W'(DICT_LIMIT));

  always_comb begin
    state_nxt    = state_r;
    prefix_nxt   = prefix_r;
    pv_nxt       = pv_r;
    nfc_nxt      = nfc_r;
    h_nxt        = h_r;
    key_nxt      = key_r;
    byte_nxt     = byte_r;
    eos_nxt      = eos_r;
    res_code_nxt = res_code_r;
    res_bits_nxt = res_bits_r;
    ov_nxt       = ov_r && !out_ready;
    oc_nxt       = oc_r;
    ob_nxt       = ob_r;
    ol_nxt       = ol_r;
    item_pop     = 1'b0;
    do_miss      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (item_valid) begin
          item_pop = 1'b1;
          byte_nxt = item.data_byte;
          eos_nxt  = item.eos;
          if (!pv_r) begin
            prefix_nxt = {4'b0, item.data_byte};
            pv_nxt     = 1'b1;
            state_nxt  = S_EOS;
          end else begin
            key_nxt   = new_key;
            h_nxt     = lzw_pkg::hash_key(new_key);
            state_nxt = S_PA;
          end
        end
      end
      S_PA: begin
        if (cand) begin
          state_nxt = S_PB;
        end else begin
          do_miss = 1'b1;
        end
      end
      S_PB: begin
        if (live && (entry_q_r[lzw_pkg::KEY_W+lzw_pkg::HASH_AW-1:lzw_pkg::HASH_AW] == key_r))
        begin
          prefix_nxt = hash_q_r;
          state_nxt  = S_EOS;
        end else if (live) begin
          h_nxt     = h_r + 1'b1;
          state_nxt = S_PA;
        end else begin
          do_miss = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          oc_nxt    = res_code_r;
          ob_nxt    = res_bits_r;
          ol_nxt    = 1'b0;
          state_nxt = S_EOS;
        end
      end
      S_EOS: begin
        if (!eos_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          ov_nxt     = 1'b1;
          oc_nxt     = prefix_r;
          ob_nxt     = lzw_pkg::width_for(nfc_r);
          ol_nxt     = 1'b1;
          prefix_nxt = '0;
          pv_nxt     = 1'b0;
          nfc_nxt    = lzw_pkg::FIRST_CODE;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (do_miss) begin
      res_code_nxt = prefix_r;
      res_bits_nxt = lzw_pkg::width_for(nfc_r);
      prefix_nxt   = {4'b0, byte_r};
      state_nxt    = S_EMIT;
      if (do_ins) begin
        nfc_nxt = nfc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_ins) begin
      hash_mem[h_r]      <= nfc_r[lzw_pkg::CODE_W-1:0];
      entry_mem[ent_wr]  <= {key_r, h_r};
    end
    hash_q_r  <= hash_mem[h_nxt];
    entry_q_r <= entry_mem[ent_rd];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      prefix_r <= '0;
      pv_r     <= 1'b0;
      nfc_r    <= lzw_pkg::FIRST_CODE;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      prefix_r <= prefix_nxt;
      pv_r     <= pv_nxt;
      nfc_r    <= nfc_nxt;
      ov_r     <= ov_nxt;
    end
    h_r        <= h_nxt;
    key_r      <= key_nxt;
    byte_r     <= byte_nxt;
    eos_r      <= eos_nxt;
    res_code_r <= res_code_nxt;
    res_bits_r <= res_bits_nxt;
    oc_r       <= oc_nxt;
    ob_r       <= ob_nxt;
    ol_r       <= ol_nxt;
  end

`ifndef SYNTHESIS
  a_empty_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    !pv_r |-> (nfc_r == lzw_pkg::FIRST_CODE && prefix_r == '0))
    else $error("no prefix held but dictionary not empty");
  a_nfc_range: assert property (@(posedge clk) disable iff (!rst_n)
    nfc_r >= lzw_pkg::FIRST_CODE && nfc_r <= lzw_pkg::NFC_W'(DICT_LIMIT))
    else $error("next free code out of range");
  a_pb_after_pa: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PB |-> $past(state_r) == S_PA)
    else $error("entry check without a hash read");
`endif

endmodule

[rtl/lzw_compressor.sv]
// Flow: a byte is registered in the input queue before the core takes it. Each
// hash probe reads the hash table (S_PA) and then checks the entry (S_PB); a
// miss found in S_PA skips S_PB. A miss code is registered in S_EMIT, and a
// flushed code after it in S_EOS. The core takes a new byte only back in S_IDLE,
// once through with the last; output stalls hold it in S_EMIT or S_EOS.
// Reset is synchronous and active low; it empties the dictionary at once.
// ----------------------------------------------------------------------------
// lzw_compressor
// LZW compressor with variable-width output codes and a frozen dictionary.
// ----------------------------------------------------------------------------
module lzw_compressor #(
  parameter int DICT_SIZE = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_code,
  output logic [3:0]  out_code_bits,
  output logic        out_last_code
);

  logic           item_valid, item_pop;
  lzw_pkg::item_t item;

  lzw_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_stream (in_end_of_stream),
    .item_valid       (item_valid),
    .item             (item),
    .item_pop         (item_pop)
  );

  lzw_core #(.DICT_SIZE(DICT_SIZE)) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item          (item),
    .item_pop      (item_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_code      (out_code),
    .out_code_bits (out_code_bits),
    .out_last_code (out_last_code)
  );

endmodule
